FILE: rtl/core/prdt_pkg.sv
// Shared types and constants for the point rotation unit.
`default_nettype none

package prdt_pkg;

  // Fixed field widths of the beats
  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;

  // Default fraction bits of the rotation coefficients
  localparam int FRAC_BITS_DEF = 14;

  // Cos/sin table: 0..45 degrees, unsigned Q1.14 entries
  localparam int TBL_FRAC  = 14;
  localparam int TBL_W     = TBL_FRAC + 1;
  localparam int TBL_DEPTH = 46;

  // Reduced angle 0..359
  localparam int DEG_WIDTH = 9;

  // Angle landmarks
  localparam int DEG_FULL  = 360;
  localparam int DEG_HALF  = 180;
  localparam int DEG_RIGHT = 90;
  localparam int DEG_OCT   = 45;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [ANGLE_WIDTH-1:0] angle_deg;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/prdt_trig.sv
// Folds a 0..359 degree angle into the 0..45 table and gives signed cos/sin.
`default_nettype none

module prdt_trig #(
  parameter int FRAC_BITS = prdt_pkg::FRAC_BITS_DEF
) (
  input  wire logic [prdt_pkg::DEG_WIDTH-1:0] deg,
  output logic signed [FRAC_BITS+1:0]         cos_o,
  output logic signed [FRAC_BITS+1:0]         sin_o
);

  localparam int TW    = prdt_pkg::TBL_W;
  localparam int IDX_W = $clog2(prdt_pkg::TBL_DEPTH);
  localparam int MAG_W = FRAC_BITS + 1;

  localparam logic [TW-1:0] COS_ROM [prdt_pkg::TBL_DEPTH] = '{
    15'd16384, 15'd16382, 15'd16374, 15'd16362, 15'd16344, 15'd16322, 15'd16294,
    15'd16262, 15'd16225, 15'd16182, 15'd16135, 15'd16083, 15'd16026, 15'd15964,
    15'd15897, 15'd15826, 15'd15749, 15'd15668, 15'd15582, 15'd15491, 15'd15396,
    15'd15296, 15'd15191, 15'd15082, 15'd14968, 15'd14849, 15'd14726, 15'd14598,
    15'd14466, 15'd14330, 15'd14189, 15'd14044, 15'd13894, 15'd13741, 15'd13583,
    15'd13421, 15'd13255, 15'd13085, 15'd12911, 15'd12733, 15'd12551, 15'd12365,
    15'd12176, 15'd11982, 15'd11786, 15'd11585
  };

  localparam logic [TW-1:0] SIN_ROM [prdt_pkg::TBL_DEPTH] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585
  };

  logic [7:0]       a1;
  logic [6:0]       a2;
  logic [IDX_W-1:0] idx;
  logic             neg_s;
  logic             neg_c;
  logic             swap;
  logic [TW-1:0]    c_raw;
  logic [TW-1:0]    s_raw;
  logic [MAG_W-1:0] c_mag;
  logic [MAG_W-1:0] s_mag;

  // Symmetry folds: lower half, first quadrant, first octant
  always_comb begin
    neg_s = (deg > prdt_pkg::DEG_WIDTH'(prdt_pkg::DEG_HALF));
    a1    = neg_s ? 8'(prdt_pkg::DEG_WIDTH'(prdt_pkg::DEG_FULL) - deg) : deg[7:0];
    neg_c = (a1 > 8'(prdt_pkg::DEG_RIGHT));
    a2    = neg_c ? 7'(8'(prdt_pkg::DEG_HALF) - a1) : a1[6:0];
    swap  = (a2 > 7'(prdt_pkg::DEG_OCT));
    idx   = swap ? IDX_W'(7'(prdt_pkg::DEG_RIGHT) - a2) : a2[IDX_W-1:0];
  end

  // Table read, cos/sin swapped past the octant
  always_comb begin
    c_raw = swap ? SIN_ROM[idx] : COS_ROM[idx];
    s_raw = swap ? COS_ROM[idx] : SIN_ROM[idx];
  end

  // Rescale Q1.14 entries to the coefficient fraction width
  if (FRAC_BITS >= prdt_pkg::TBL_FRAC) begin : g_up
    localparam int UP = FRAC_BITS - prdt_pkg::TBL_FRAC;
    assign c_mag = MAG_W'(c_raw) << UP;
    assign s_mag = MAG_W'(s_raw) << UP;
  end else begin : g_dn
    // round half up on the magnitude
    localparam int DN = prdt_pkg::TBL_FRAC - FRAC_BITS;
    localparam logic [TW:0] HALF = (TW+1)'(1) << (DN - 1);
    logic [TW:0] c_sum;
    logic [TW:0] s_sum;
    assign c_sum = {1'b0, c_raw} + HALF;
    assign s_sum = {1'b0, s_raw} + HALF;
    assign c_mag = MAG_W'(c_sum >> DN);
    assign s_mag = MAG_W'(s_sum >> DN);
  end

  // Apply quadrant signs
  always_comb begin
    cos_o = neg_c ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
    sin_o = neg_s ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  end

endmodule

`default_nettype wire

FILE: rtl/core/prdt_round.sv
// Drops fraction bits of a product sum toward zero and saturates to a coordinate.
`default_nettype none

module prdt_round #(
  parameter int FRAC_BITS = prdt_pkg::FRAC_BITS_DEF,
  parameter int SUM_W     = prdt_pkg::COORD_WIDTH + prdt_pkg::FRAC_BITS_DEF + 3
) (
  input  wire logic signed [SUM_W-1:0]                acc,
  output logic signed [prdt_pkg::COORD_WIDTH-1:0]     res
);

  localparam int CW = prdt_pkg::COORD_WIDTH;
  localparam int QW = SUM_W - FRAC_BITS;

  logic [SUM_W-1:0] bias;
  logic [SUM_W-1:0] adj;
  logic [QW-1:0]    quo;
  logic [QW-CW:0]   upper;
  logic             fits;

  // Negative sums get 2^F-1 added so the shift truncates toward zero
  always_comb begin
    bias  = acc[SUM_W-1] ? SUM_W'({FRAC_BITS{1'b1}}) : '0;
    adj   = acc + bias;
    quo   = adj[SUM_W-1:FRAC_BITS];
    upper = quo[QW-1:CW-1];
    fits  = (&upper) || !(|upper);
  end

  // Saturate to the signed coordinate range
  always_comb begin
    if (fits) begin
      res = quo[CW-1:0];
    end else if (quo[QW-1]) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/point_rotation_degree_table_unit.sv
// Top level: rotates a point by a whole-degree angle through a cos/sin table.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+---------------------------
//   in_     | input     | in_valid / in_ready   | in_beat_t  (x, y, angle)
//   out_    | output    | out_valid / out_ready | out_beat_t (rotated x, y)
//
// One beat per clock sustained while out_ready stays high; each beat passes every stage in turn.
// The five stages are: input register, angle reduction (reciprocal multiply),
// fold and table lookup, four parallel multipliers, sum/truncate/saturate.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled output holds only as far back as the pipe is full.
// Reset (rst_n low, synchronous) clears the stage valids; the table is constant.
`default_nettype none

module point_rotation_degree_table_unit #(
  parameter int FRAC_BITS = prdt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire prdt_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output prdt_pkg::out_beat_t     out_data
);

  localparam int CW      = prdt_pkg::COORD_WIDTH;
  localparam int AW      = prdt_pkg::ANGLE_WIDTH;
  localparam int DW      = prdt_pkg::DEG_WIDTH;
  localparam int COEF_W  = FRAC_BITS + 2;
  localparam int PROD_W  = CW + COEF_W;
  localparam int SUM_W   = PROD_W + 1;

  // Angle reduction: bias to a positive multiple of 360, then reciprocal
  localparam int ANGLE_BIAS  = 33120;          // 92 * 360, covers the full range
  localparam int U_W         = AW + 1;
  localparam int RECIP_360   = 2912;           // floor(2^20 / 360)
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 20;
  localparam int RP_W        = U_W + RECIP_W;
  localparam int Q_W         = 8;
  localparam int REM_W       = 10;

  // Stage indexes
  localparam int S_IN   = 0;
  localparam int S_MOD  = 1;
  localparam int S_TRIG = 2;
  localparam int S_MUL  = 3;
  localparam int S_OUT  = 4;
  localparam int NSTG   = 5;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  prdt_pkg::in_beat_t     in_r;

  logic [U_W-1:0]         u_r, u_nxt;
  logic [Q_W-1:0]         q_r, q_nxt;
  logic [RP_W-1:0]        recip_prod;
  logic signed [CW-1:0]   x1_r, y1_r;

  logic [U_W-1:0]         rem_full;
  logic [REM_W-1:0]       rem;
  logic [DW-1:0]          deg;
  logic signed [COEF_W-1:0] cos_nxt, sin_nxt;
  logic signed [COEF_W-1:0] cos_r, sin_r;
  logic signed [CW-1:0]   x2_r, y2_r;

  logic signed [PROD_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;

  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [CW-1:0]    rx_nxt, ry_nxt;
  prdt_pkg::out_beat_t     out_r;

  // Stage advance, from the output back
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[S_IN];
  assign out_valid = vld_r[S_OUT];
  assign out_data  = out_r;

  // Valid bits move with their stage
  always_comb begin
    vld_nxt = vld_r;
    if (adv[S_IN]) begin
      vld_nxt[S_IN] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Angle reduction: quotient estimate is exact or one low
  always_comb begin
    u_nxt      = U_W'($signed(in_r.angle_deg)) + U_W'(ANGLE_BIAS);
    recip_prod = RP_W'(u_nxt) * RP_W'(RECIP_360);
    q_nxt      = recip_prod[RECIP_SHIFT +: Q_W];
  end

  // Remainder with one correction step
  always_comb begin
    rem_full = u_r - U_W'(U_W'(q_r) * U_W'(prdt_pkg::DEG_FULL));
    rem      = rem_full[REM_W-1:0];
    if (rem >= REM_W'(prdt_pkg::DEG_FULL)) begin
      deg = DW'(rem - REM_W'(prdt_pkg::DEG_FULL));
    end else begin
      deg = rem[DW-1:0];
    end
  end

  prdt_trig #(
    .FRAC_BITS (FRAC_BITS)
  ) u_trig (
    .deg   (deg),
    .cos_o (cos_nxt),
    .sin_o (sin_nxt)
  );

  // Product sums
  always_comb begin
    sum_x = SUM_W'(pxc_r) - SUM_W'(pys_r);
    sum_y = SUM_W'(pxs_r) + SUM_W'(pyc_r);
  end

  prdt_round #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_round_x (
    .acc (sum_x),
    .res (rx_nxt)
  );

  prdt_round #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_round_y (
    .acc (sum_y),
    .res (ry_nxt)
  );

  // Stage payload registers
  always_ff @(posedge clk) begin
    if (adv[S_IN]) begin
      in_r <= in_data;
    end
    if (adv[S_MOD]) begin
      u_r  <= u_nxt;
      q_r  <= q_nxt;
      x1_r <= in_r.in_x;
      y1_r <= in_r.in_y;
    end
    if (adv[S_TRIG]) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
    end
    if (adv[S_MUL]) begin
      pxc_r <= PROD_W'(x2_r) * PROD_W'(cos_r);
      pys_r <= PROD_W'(y2_r) * PROD_W'(sin_r);
      pxs_r <= PROD_W'(x2_r) * PROD_W'(sin_r);
      pyc_r <= PROD_W'(y2_r) * PROD_W'(cos_r);
    end
    if (adv[S_OUT]) begin
      out_r.out_x <= rx_nxt;
      out_r.out_y <= ry_nxt;
    end
  end

endmodule

`default_nettype wire
